/* rtl/dpo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpo_pkg
// Shared types and codes of the depth pyramid occlusion block.
// ----------------------------------------------------------------------------
package dpo_pkg;

	localparam int LEVEL_SLOTS = 16;
	localparam int LEVEL_BITS  = 4;
	localparam int RECT_BITS   = 13;
	localparam int DEPTH_FIELD = 24;

	localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_PYRAMID_VALID = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_REDUCE = 2'd2,
		CMD_QUERY  = 2'd3
	} command_t;

	typedef struct packed {
		command_t                command;
		logic [7:0]              texel_x;
		logic [7:0]              texel_y;
		logic [DEPTH_FIELD-1:0]  texel_depth;
		logic [RECT_BITS-1:0]    rect_left;
		logic [RECT_BITS-1:0]    rect_top;
		logic [RECT_BITS-1:0]    rect_right;
		logic [RECT_BITS-1:0]    rect_bottom;
		logic [DEPTH_FIELD-1:0]  rect_nearest;
		logic                    rect_usable;
	} item_t;

	typedef struct packed {
		logic                  occluded;
		logic [LEVEL_BITS-1:0] level_used;
	} result_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic                  empty;
	} pick_t;

endpackage

/* rtl/dpo_level_pick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpo_level_pick
// Picks the pyramid level for a query rectangle and flags an empty footprint.
// ----------------------------------------------------------------------------
module dpo_level_pick
	import dpo_pkg::*;
#(
	parameter int FRACTION_BITS = 4
) (
	input  logic [RECT_BITS-1:0]  rect_left,
	input  logic [RECT_BITS-1:0]  rect_top,
	input  logic [RECT_BITS-1:0]  rect_right,
	input  logic [RECT_BITS-1:0]  rect_bottom,
	input  logic [LEVEL_BITS-1:0] last_level,
	output pick_t                 pick
);

	logic signed [15:0] dx, dy, span;
	logic [4:0]         cnt;

	assign dx   = $signed({3'b000, rect_right}) - $signed({3'b000, rect_left});
	assign dy   = $signed({3'b000, rect_bottom}) - $signed({3'b000, rect_top});
	assign span = (dx > dy) ? dx : dy;

	// span above each power of two is a thermometer; count its ones
	always_comb begin
		cnt = '0;
		for (int k = 0; k < 24; k++) begin
			if (k + FRACTION_BITS <= 13) begin
				if (span > (16'sd1 <<< (k + FRACTION_BITS))) begin
					cnt = cnt + 5'd1;
				end
			end
		end
	end

	assign pick.level = (cnt > {1'b0, last_level}) ? last_level : cnt[3:0];
	assign pick.empty = (rect_left > rect_right) || (rect_top > rect_bottom);

endmodule

/* rtl/depth_pyramid_occlusion.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pyramid_occlusion
// Reversed-Z depth pyramid with clear, texel write, min-reduce and
// rectangle occlusion query.
// ----------------------------------------------------------------------------
// Usage:
//   item/item_valid/item_stall carries one command per transaction; the
//   block raises item_stall while a command runs. Every command returns one
//   transaction on result/result_valid/result_stall, held in an output
//   register, so a stalled receiver only delays the end of the command.
//   cfg_write/cfg_index/cfg_data writes the size and valid registers.
// Work from acceptance to result runs through the single-port read pipeline
// and the one shared multiplier that forms every texel address (row * width):
//   write   one write issued, skipped when the texel lies off the image
//   query   level pick, footprint setup, one read per footprint texel (at most 4)
//   reduce  per parent texel, all levels: setup, footprint reads (at most 4), write
//   clear   one memory entry per cycle: MAX_WIDTH*MAX_HEIGHT*4/3
//           + 2*(MAX_WIDTH+MAX_HEIGHT) + 16 entries
// The next command is taken the cycle after its result is loaded.
// Reset and every size write first rebuild the level table (up to 16
// levels, one level per cycle) and then run the same clearing pass; items
// are stalled meanwhile, configuration writes are still taken.
// ----------------------------------------------------------------------------
module depth_pyramid_occlusion
	import dpo_pkg::*;
#(
	parameter int MAX_WIDTH     = 256,
	parameter int MAX_HEIGHT    = 256,
	parameter int DEPTH_BITS    = 24,
	parameter int FRACTION_BITS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	localparam int SLOTS = (MAX_WIDTH * MAX_HEIGHT * 4) / 3
		+ 2 * (MAX_WIDTH + MAX_HEIGHT) + 16;
	localparam int AW = $clog2(SLOTS);
	localparam int DW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_BUILD = 12'b0000_0000_0010,
		S_CLEAR = 12'b0000_0000_0100,
		S_WRT   = 12'b0000_0000_1000,
		S_RSET  = 12'b0000_0001_0000,
		S_RTEX  = 12'b0000_0010_0000,
		S_RD    = 12'b0000_0100_0000,
		S_DRAIN = 12'b0000_1000_0000,
		S_RWR   = 12'b0001_0000_0000,
		S_QLVL  = 12'b0010_0000_0000,
		S_QFP   = 12'b0100_0000_0000,
		S_FIN   = 12'b1000_0000_0000
	} state_t;

	function automatic logic [DW-1:0] lw_of(input logic [DW-1:0] s, input logic [3:0] lv);
		return ((s - DW'(1)) >> lv) + DW'(1);
	endfunction

	function automatic logic [HW-1:0] lh_of(input logic [HW-1:0] s, input logic [3:0] lv);
		return ((s - HW'(1)) >> lv) + HW'(1);
	endfunction

	function automatic logic [DEPTH_BITS-1:0] mask_depth(input logic [DEPTH_FIELD-1:0] d);
		logic [31:0] d32;
		d32 = 32'(d);
		return d32[DEPTH_BITS-1:0];
	endfunction

	function automatic logic [DW-1:0] sat_w(input logic [8:0] v);
		if (v == 9'd0) return DW'(1);
		if (32'(v) > 32'(MAX_WIDTH)) return DW'(MAX_WIDTH);
		return DW'(v);
	endfunction

	function automatic logic [HW-1:0] sat_h(input logic [8:0] v);
		if (v == 9'd0) return HW'(1);
		if (32'(v) > 32'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
		return HW'(v);
	endfunction

	function automatic logic [XW-1:0] tex_x(input logic [RECT_BITS-1:0] c,
			input logic [4:0] sh, input logic [DW-1:0] lim);
		logic [RECT_BITS-1:0] t;
		t = c >> sh;
		return (32'(t) < 32'(lim)) ? XW'(t) : XW'(lim - DW'(1));
	endfunction

	function automatic logic [YW-1:0] tex_y(input logic [RECT_BITS-1:0] c,
			input logic [4:0] sh, input logic [HW-1:0] lim);
		logic [RECT_BITS-1:0] t;
		t = c >> sh;
		return (32'(t) < 32'(lim)) ? YW'(t) : YW'(lim - HW'(1));
	endfunction

	state_t state_q;

	// configuration and level table
	logic [DW-1:0]   width_q;
	logic [HW-1:0]   height_q;
	logic            valid_q;
	logic [AW-1:0]   base_q [LEVEL_SLOTS];
	logic [3:0]      last_q, blv_q;
	logic [AW-1:0]   bacc_q, clr_q;
	logic            res_q;

	// command context
	item_t           item_q;
	logic [3:0]      lvl_q, rdl_q, lvlo_q;
	logic [XW-1:0]   cx_q, x0_q, x1_q, px_q;
	logic [YW-1:0]   cy_q, y0_q, y1_q, py_q;
	logic [DEPTH_BITS-1:0] acc_q;
	logic            occ_q;

	// address / access pipeline
	logic            v_s1, wr_s1, v_s2;
	logic [XW-1:0]   x_s1;
	logic [AW-1:0]   prod_s1, base_s1;
	logic [DEPTH_BITS-1:0] data_s1, rdata_s2;

	logic [DEPTH_BITS-1:0] mem [SLOTS];

	logic            item_acc, out_acc, in_range;
	logic [DW-1:0]   b_w, l_w, c_w, i_w;
	logic [HW-1:0]   b_h, l_h, c_h;
	logic            issue, issue_wr;
	logic [YW-1:0]   row;
	logic [XW-1:0]   col;
	logic [3:0]      ilvl;
	logic [DEPTH_BITS-1:0] idata;
	logic [HW-1:0]   mul_a;
	logic [DW-1:0]   mul_b;
	logic [HW+DW-1:0] prod_full;
	logic [AW-1:0]   prod, addr_s1;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [DEPTH_BITS-1:0] wdata, nearest;
	logic [XW:0]     x1c;
	logic [YW:0]     y1c;
	logic [XW-1:0]   x0n, x1n, qx0, qx1;
	logic [YW-1:0]   y0n, y1n, qy0, qy1;
	logic [4:0]      qsh;
	pick_t           pick;

	assign item_stall = (state_q != S_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign out_acc    = result_valid && !result_stall;
	assign nearest    = mask_depth(item_q.rect_nearest);

	dpo_level_pick #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_pick (
		.rect_left  (item_q.rect_left),
		.rect_top   (item_q.rect_top),
		.rect_right (item_q.rect_right),
		.rect_bottom(item_q.rect_bottom),
		.last_level (last_q),
		.pick       (pick)
	);

	// level geometry: build counter, operating level and its children
	assign b_w = lw_of(width_q, blv_q);
	assign b_h = lh_of(height_q, blv_q);
	assign l_w = lw_of(width_q, lvl_q);
	assign l_h = lh_of(height_q, lvl_q);
	assign c_w = lw_of(width_q, 4'(lvl_q - 4'd1));
	assign c_h = lh_of(height_q, 4'(lvl_q - 4'd1));
	assign i_w = lw_of(width_q, ilvl);

	// child footprint of a parent texel; the odd last column and row fold in by clamping
	assign x0n = XW'({px_q, 1'b0});
	assign x1c = {px_q, 1'b1};
	assign x1n = (32'(x1c) > 32'(c_w - DW'(1))) ? XW'(c_w - DW'(1)) : XW'(x1c);
	assign y0n = YW'({py_q, 1'b0});
	assign y1c = {py_q, 1'b1};
	assign y1n = (32'(y1c) > 32'(c_h - HW'(1))) ? YW'(c_h - HW'(1)) : YW'(y1c);

	// query footprint at the chosen level
	assign qsh = 5'(FRACTION_BITS) + 5'(lvl_q);
	assign qx0 = tex_x(item_q.rect_left, qsh, l_w);
	assign qx1 = tex_x(item_q.rect_right, qsh, l_w);
	assign qy0 = tex_y(item_q.rect_top, qsh, l_h);
	assign qy1 = tex_y(item_q.rect_bottom, qsh, l_h);

	assign in_range = (32'(item_q.texel_x) < 32'(width_q))
		&& (32'(item_q.texel_y) < 32'(height_q));

	// one access a cycle into the address pipeline
	always_comb begin
		issue    = 1'b0;
		issue_wr = 1'b0;
		row      = '0;
		col      = '0;
		ilvl     = '0;
		idata    = '0;
		case (state_q)
			S_RD: begin
				issue = 1'b1;
				row   = cy_q;
				col   = cx_q;
				ilvl  = rdl_q;
			end
			S_WRT: begin
				issue    = in_range;
				issue_wr = 1'b1;
				row      = YW'(item_q.texel_y);
				col      = XW'(item_q.texel_x);
				idata    = mask_depth(item_q.texel_depth);
			end
			S_RWR: begin
				issue    = 1'b1;
				issue_wr = 1'b1;
				row      = py_q;
				col      = px_q;
				ilvl     = lvl_q;
				idata    = acc_q;
			end
			default: begin
			end
		endcase
	end

	// the shared multiplier: level sizes while building, row offsets otherwise
	assign mul_a     = (state_q == S_BUILD) ? b_h : HW'(row);
	assign mul_b     = (state_q == S_BUILD) ? b_w : i_w;
	assign prod_full = mul_a * mul_b;
	assign prod      = AW'(prod_full);
	assign addr_s1   = base_s1 + prod_s1 + AW'(x_s1);

	assign we    = (state_q == S_CLEAR) || (v_s1 && wr_s1);
	assign waddr = (state_q == S_CLEAR) ? clr_q : addr_s1;
	assign wdata = (state_q == S_CLEAR) ? '0 : data_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s2 <= mem[addr_s1];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_BUILD) begin
			base_q[blv_q] <= bacc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_BUILD;
			width_q      <= sat_w(9'd256);
			height_q     <= sat_h(9'd256);
			valid_q      <= 1'b0;
			last_q       <= '0;
			blv_q        <= '0;
			bacc_q       <= '0;
			clr_q        <= '0;
			res_q        <= 1'b0;
			item_q       <= '0;
			lvl_q        <= '0;
			rdl_q        <= '0;
			lvlo_q       <= '0;
			cx_q         <= '0;
			x0_q         <= '0;
			x1_q         <= '0;
			px_q         <= '0;
			cy_q         <= '0;
			y0_q         <= '0;
			y1_q         <= '0;
			py_q         <= '0;
			acc_q        <= DEPTH_MAX;
			occ_q        <= 1'b0;
			v_s1         <= 1'b0;
			wr_s1        <= 1'b0;
			v_s2         <= 1'b0;
			x_s1         <= '0;
			prod_s1      <= '0;
			base_s1      <= '0;
			data_s1      <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			// advance the access pipeline
			v_s1    <= issue;
			wr_s1   <= issue_wr;
			x_s1    <= col;
			prod_s1 <= prod;
			base_s1 <= base_q[ilvl];
			data_s1 <= idata;
			v_s2    <= v_s1 && !wr_s1;
			if (v_s2 && (rdata_s2 < acc_q)) begin
				acc_q <= rdata_s2;
			end

			// drop the result once taken, unless the final state reloads it
			if (out_acc && (state_q != S_FIN)) begin
				result_valid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						item_q <= item;
						occ_q  <= 1'b0;
						lvlo_q <= '0;
						acc_q  <= DEPTH_MAX;
						case (item.command)
							CMD_CLEAR: begin
								clr_q   <= '0;
								res_q   <= 1'b1;
								state_q <= S_CLEAR;
							end
							CMD_WRITE:  state_q <= S_WRT;
							CMD_REDUCE: state_q <= S_RSET;
							default:    state_q <= S_QLVL;
						endcase
					end
				end
				S_BUILD: begin
					bacc_q <= bacc_q + prod;
					if (((b_w <= DW'(1)) && (b_h <= HW'(1)))
							|| (blv_q == 4'(LEVEL_SLOTS - 1))) begin
						last_q  <= blv_q;
						clr_q   <= '0;
						res_q   <= 1'b0;
						state_q <= S_CLEAR;
					end else begin
						blv_q <= blv_q + 4'd1;
					end
				end
				S_CLEAR: begin
					if (clr_q == AW'(SLOTS - 1)) begin
						state_q <= res_q ? S_FIN : S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_WRT: state_q <= S_DRAIN;
				S_RSET: begin
					lvl_q   <= 4'd1;
					px_q    <= '0;
					py_q    <= '0;
					state_q <= (last_q == 4'd0) ? S_FIN : S_RTEX;
				end
				S_RTEX: begin
					cx_q    <= x0n;
					x0_q    <= x0n;
					x1_q    <= x1n;
					cy_q    <= y0n;
					y0_q    <= y0n;
					y1_q    <= y1n;
					rdl_q   <= 4'(lvl_q - 4'd1);
					state_q <= S_RD;
				end
				S_RD: begin
					if (cx_q == x1_q) begin
						cx_q <= x0_q;
						if (cy_q == y1_q) begin
							state_q <= S_DRAIN;
						end else begin
							cy_q <= cy_q + YW'(1);
						end
					end else begin
						cx_q <= cx_q + XW'(1);
					end
				end
				S_DRAIN: begin
					// hold until the last read has reached the minimum
					if (!v_s1 && !v_s2) begin
						case (item_q.command)
							CMD_REDUCE: state_q <= S_RWR;
							CMD_QUERY: begin
								occ_q   <= (nearest < acc_q);
								lvlo_q  <= lvl_q;
								state_q <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_RWR: begin
					acc_q <= DEPTH_MAX;
					if (px_q == XW'(l_w - DW'(1))) begin
						px_q <= '0;
						if (py_q == YW'(l_h - HW'(1))) begin
							py_q <= '0;
							if (lvl_q == last_q) begin
								state_q <= S_FIN;
							end else begin
								lvl_q   <= lvl_q + 4'd1;
								state_q <= S_RTEX;
							end
						end else begin
							py_q    <= py_q + YW'(1);
							state_q <= S_RTEX;
						end
					end else begin
						px_q    <= px_q + XW'(1);
						state_q <= S_RTEX;
					end
				end
				S_QLVL: begin
					if (!(valid_q && item_q.rect_usable)) begin
						state_q <= S_FIN;
					end else begin
						lvl_q <= pick.level;
						if (pick.empty) begin
							lvlo_q  <= pick.level;
							state_q <= S_FIN;
						end else begin
							state_q <= S_QFP;
						end
					end
				end
				S_QFP: begin
					cx_q    <= qx0;
					x0_q    <= qx0;
					x1_q    <= qx1;
					cy_q    <= qy0;
					y0_q    <= qy0;
					y1_q    <= qy1;
					rdl_q   <= lvl_q;
					state_q <= S_RD;
				end
				S_FIN: begin
					if (!result_valid || !result_stall) begin
						result.occluded   <= occ_q;
						result.level_used <= lvlo_q;
						result_valid      <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// a size write acts as a resize: rebuild levels and clear the store
			if (cfg_write) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						width_q <= sat_w(cfg_data);
						valid_q <= 1'b0;
						blv_q   <= '0;
						bacc_q  <= '0;
						state_q <= S_BUILD;
					end
					REG_IMAGE_HEIGHT: begin
						height_q <= sat_h(cfg_data);
						valid_q  <= 1'b0;
						blv_q    <= '0;
						bacc_q   <= '0;
						state_q  <= S_BUILD;
					end
					REG_PYRAMID_VALID: valid_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

/* rtl/dpo_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpo_checker
// Port-level checks of the depth pyramid occlusion block.
// ----------------------------------------------------------------------------
module dpo_checker
	import dpo_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// a stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// an accepted command keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("block ready right after accepting a command");

	// results only appear at the end of a busy period
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without a running command");

	// the clearing pass follows reset
	a_clear_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> item_stall)
		else $error("block ready before the clearing pass");

endmodule

bind depth_pyramid_occlusion dpo_checker u_dpo_checker (.*);
